>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue cell row.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 16;
    localparam int CAP_W         = 5;
    localparam int INFO_W        = 8;
    localparam int CAP_RESET     = 16;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_ENQUEUED   = 2'd0,
        ST_DEQUEUED   = 2'd1,
        ST_FULL       = 2'd2,
        ST_EMPTY      = 2'd3
    } t_status;

    // Per-cycle operation broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } t_op;

endpackage

>>> rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds a time/info pair, inserts or shifts.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int TIME_BITS = 16,
    parameter int CNT_W     = 5,
    parameter int INDEX     = 0
) (
    input  logic                   i_clk,
    input  spq_pkg::t_op           i_op,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [TIME_BITS-1:0]   i_key,
    input  logic [spq_pkg::INFO_W-1:0] i_info,
    input  logic                   i_left_gt,
    input  logic [TIME_BITS-1:0]   i_left_time,
    input  logic [spq_pkg::INFO_W-1:0] i_left_info,
    input  logic [TIME_BITS-1:0]   i_right_time,
    input  logic [spq_pkg::INFO_W-1:0] i_right_info,
    output logic                   o_gt,
    output logic [TIME_BITS-1:0]   o_time,
    output logic [spq_pkg::INFO_W-1:0] o_info
);
    import spq_pkg::*;

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [TIME_BITS-1:0] r_time, n_time;
    logic [INFO_W-1:0]    r_info, n_info;
    logic                 w_occ;

    // empty slots count as holding a larger time
    assign w_occ = (IDX < i_count);
    assign o_gt  = !w_occ || (r_time > i_key);

    always_comb begin
        n_time = r_time;
        n_info = r_info;
        if (i_op.enq && o_gt) begin
            if (i_left_gt) begin
                n_time = i_left_time;
                n_info = i_left_info;
            end else begin
                n_time = i_key;
                n_info = i_info;
            end
        end else if (i_op.deq) begin
            n_time = i_right_time;
            n_info = i_right_info;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time <= n_time;
        r_info <= n_info;
    end

    assign o_time = r_time;
    assign o_info = r_info;

endmodule

>>> rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Fill count, capacity register, full/empty checks and result registers.
// ----------------------------------------------------------------------------
module spq_ctrl #(
    parameter int DEPTH     = 16,
    parameter int TIME_BITS = 16,
    parameter int CNT_W     = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [spq_pkg::CAP_W-1:0]   i_cfg_wdata,
    input  logic                        i_accept,
    input  logic                        i_command,
    input  logic [TIME_BITS-1:0]        i_head_time,
    input  logic [spq_pkg::INFO_W-1:0]  i_head_info,
    output logic                        o_ready,
    output spq_pkg::t_op                o_op,
    output logic [CNT_W-1:0]            o_count,
    output logic                        o_done,
    output spq_pkg::t_status            o_status,
    output logic [TIME_BITS-1:0]        o_out_time,
    output logic [spq_pkg::INFO_W-1:0]  o_out_payload,
    output logic [CNT_W-1:0]            o_occupancy
);
    import spq_pkg::*;

    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    logic                 r_ready;
    logic [CAP_W-1:0]     r_capacity;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_done;
    t_status              r_status, n_status;
    logic [TIME_BITS-1:0] r_out_time, n_out_time;
    logic [INFO_W-1:0]    r_out_info, n_out_info;
    logic                 w_full, w_empty;

    assign w_full  = (CMP_W'(r_count) >= CMP_W'(r_capacity)) || (r_count == CNT_MAX);
    assign w_empty = (r_count == '0);

    always_comb begin
        o_op       = '0;
        n_count    = r_count;
        n_status   = r_status;
        n_out_time = '0;
        n_out_info = '0;
        if (i_command == CMD_ENQ) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_status  = ST_ENQUEUED;
                o_op.enq  = i_accept;
                n_count   = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status   = ST_DEQUEUED;
                o_op.deq   = i_accept;
                n_count    = r_count - CNT_W'(1);
                n_out_time = i_head_time;
                n_out_info = i_head_info;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready    <= 1'b0;
            r_capacity <= CAP_W'(CAP_RESET);
            r_count    <= '0;
            r_done     <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_done  <= i_accept;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_status   <= n_status;
            r_out_time <= n_out_time;
            r_out_info <= n_out_info;
        end
    end

    assign o_ready       = r_ready;
    assign o_count       = r_count;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_out_time    = r_out_time;
    assign o_out_payload = r_out_info;
    assign o_occupancy   = r_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("fill count above depth");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_done)
        else $error("accepted transaction produced no result");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !w_full && i_command == CMD_ENQ) |=>
            (r_count == $past(r_count) + CNT_W'(1)))
        else $error("enqueue did not bump count");

    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_status == ST_FULL || r_status == ST_EMPTY)) |->
            (r_out_time == '0 && r_out_info == '0))
        else $error("rejected transaction returned data");

    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_op.enq && o_op.deq))
        else $error("insert and shift-out in one cycle");
`endif

endmodule

>>> rtl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Sorted priority queue built as a row of compare/shift cells.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: drive i_command (0 enqueue, 1 dequeue), i_key_time and
//    i_payload with start high; the transaction is taken on a rising edge
//    with start high and busy low.
//  - Every transaction returns one result in the following cycle: o_done is high for
//    exactly that cycle with o_status, o_out_time, o_out_payload and
//    o_occupancy. The receiver cannot stall; it must take the result then.
//  - Throughput: one transaction per cycle. Each cell compares its key with
//    the incoming one and either holds, takes the new entry, or takes its
//    left neighbor (insert), or its right neighbor (dequeue).
//  - Full enqueue (count at capacity or DEPTH) and empty dequeue return a
//    reject status and leave the queue untouched; data outputs read zero.
//  - Capacity: i_cfg_we / i_cfg_wdata write the capacity register (reset
//    16); values above DEPTH act as DEPTH. Write only while idle.
//  - Reset (synchronous, active low) empties the queue; busy stays high after
//    reset is released until the ready register is set. No store clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = spq_pkg::TIME_BITS_DEF,
    parameter int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [spq_pkg::CAP_W-1:0]   i_cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_command,
    input  logic [TIME_BITS-1:0]        i_key_time,
    input  logic [spq_pkg::INFO_W-1:0]  i_payload,
    output logic                        o_done,
    output spq_pkg::t_status            o_status,
    output logic [TIME_BITS-1:0]        o_out_time,
    output logic [spq_pkg::INFO_W-1:0]  o_out_payload,
    output logic [CNT_W-1:0]            o_occupancy
);
    import spq_pkg::*;

    logic                 w_ready;
    logic                 w_accept;
    t_op                  w_op;
    logic [CNT_W-1:0]     w_count;

    // cell row taps
    logic [TIME_BITS-1:0] w_time [DEPTH];
    logic [INFO_W-1:0]    w_info [DEPTH];
    logic                 w_gt   [DEPTH];

    assign busy     = !w_ready;
    assign w_accept = start && w_ready;

    spq_ctrl #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_accept      (w_accept),
        .i_command     (i_command),
        .i_head_time   (w_time[0]),
        .i_head_info   (w_info[0]),
        .o_ready       (w_ready),
        .o_op          (w_op),
        .o_count       (w_count),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_out_time    (o_out_time),
        .o_out_payload (o_out_payload),
        .o_occupancy   (o_occupancy)
    );

    // Cell i takes the new entry when it is the first slot with a larger time,
    // and its left neighbor when that neighbor is also larger (shift right).
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic                 w_lgt;
        logic [TIME_BITS-1:0] w_ltime, w_rtime;
        logic [INFO_W-1:0]    w_linfo, w_rinfo;

        if (gi == 0) begin : g_head
            assign w_lgt   = 1'b0;
            assign w_ltime = i_key_time;
            assign w_linfo = i_payload;
        end else begin : g_mid
            assign w_lgt   = w_gt[gi-1];
            assign w_ltime = w_time[gi-1];
            assign w_linfo = w_info[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_rtime = w_time[gi];
            assign w_rinfo = w_info[gi];
        end else begin : g_body
            assign w_rtime = w_time[gi+1];
            assign w_rinfo = w_info[gi+1];
        end

        spq_cell #(
            .TIME_BITS (TIME_BITS),
            .CNT_W     (CNT_W),
            .INDEX     (gi)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op),
            .i_count      (w_count),
            .i_key        (i_key_time),
            .i_info       (i_payload),
            .i_left_gt    (w_lgt),
            .i_left_time  (w_ltime),
            .i_left_info  (w_linfo),
            .i_right_time (w_rtime),
            .i_right_info (w_rinfo),
            .o_gt         (w_gt[gi]),
            .o_time       (w_time[gi]),
            .o_info       (w_info[gi])
        );
    end

endmodule
